### rtl/mau_pkg.sv
// Shared types and constants of the modular arithmetic unit.
// Used by every module under rtl; depends on nothing.
package mau_pkg;

  localparam int unsigned MOD_W = 31;
  localparam int unsigned OPND_W = 64;
  localparam int unsigned EXP_W = 32;
  localparam int unsigned OP_W = 3;
  localparam logic [MOD_W-1:0] RESET_MODULUS = 31'd1000000007;

  localparam logic [OP_W-1:0] OP_REDUCE = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV = 3'd4;
  localparam logic [OP_W-1:0] OP_POW = 3'd5;
  localparam logic [OP_W-1:0] OP_NEG = 3'd6;
  localparam logic [OP_W-1:0] OP_INV = 3'd7;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV_A,
    CMD_SET_A,
    CMD_DIV_B,
    CMD_SET_B,
    CMD_SIMPLE,
    CMD_MUL_AB,
    CMD_MUL_RT,
    CMD_MUL_TT,
    CMD_MUL_QV,
    CMD_MUL_AI,
    CMD_DIV_P,
    CMD_SET_RES,
    CMD_SET_T,
    CMD_POW_INIT,
    CMD_INV_INIT,
    CMD_DIV_E,
    CMD_EUC_STEP,
    CMD_DIV_U,
    CMD_SET_INV
  } cmd_e;

  typedef struct packed {
    logic            div_done;
    logic [OP_W-1:0] op;
    logic            exp_neg;
    logic            n_zero;
    logic            n_lsb;
    logic            eb_zero;
  } status_t;

endpackage

### rtl/mau_div.sv
// Bit-serial restoring divider: 64-bit dividend by 31-bit divisor.
// Uses mau_pkg; one quotient bit per cycle, done pulses once all 64 quotient bits are in.
module mau_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mau_pkg::OPND_W-1:0]    dividend_i,
  input  logic [mau_pkg::MOD_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [mau_pkg::OPND_W-1:0]    quot_o,
  output logic [mau_pkg::MOD_W-1:0]     rem_o
);
  import mau_pkg::*;

  logic [OPND_W-1:0] quo_q, quo_d;
  logic [MOD_W-1:0]  rem_q, rem_d, dsr_q;
  logic [5:0]        cnt_q;
  logic              busy_q, done_q;
  logic [MOD_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quo_q[OPND_W-1]};
  assign fits = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d = fits ? MOD_W'(trial - {1'b0, dsr_q}) : trial[MOD_W-1:0];
    quo_d = {quo_q[OPND_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule

### rtl/mau_datapath.sv
// Datapath: operand registers, shared multiplier and divider, Euclid state.
// Uses mau_pkg and mau_div; acts on one command per cycle from mau_ctrl.
module mau_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mau_pkg::cmd_e               cmd_i,
  input  logic [mau_pkg::MOD_W-1:0]   modulus_i,
  input  logic [mau_pkg::OP_W-1:0]    op_i,
  input  logic [mau_pkg::OPND_W-1:0]  operand_a_i,
  input  logic [mau_pkg::OPND_W-1:0]  operand_b_i,
  input  logic [mau_pkg::EXP_W-1:0]   exponent_i,
  output mau_pkg::status_t            status_o,
  output logic [mau_pkg::MOD_W-1:0]   result_o,
  output logic                        equal_o,
  output logic                        less_o
);
  import mau_pkg::*;

  logic [OPND_W-1:0] xa_q, xb_q;
  logic [OP_W-1:0]   op_q;
  logic [EXP_W-1:0]  e_q;
  logic [MOD_W-1:0]  a_q, b_q, res_q, t_q, inv_q, n_q;
  logic [MOD_W:0]    ea_q, eb_q;
  logic signed [MOD_W+1:0] u_q, v_q, mul_x, mul_y;
  logic signed [2*MOD_W+3:0] prod_q;
  logic [MOD_W+1:0]  u_mag;

  logic              div_start, div_done;
  logic [OPND_W-1:0] div_dividend, div_quot;
  logic [MOD_W-1:0]  div_divisor, div_rem, inv_src;
  logic [MOD_W:0]    sum_ab;
  logic [MOD_W-1:0]  simple_res;

  function automatic logic [MOD_W-1:0] fix_sign(input logic [MOD_W-1:0] r,
                                                input logic neg,
                                                input logic [MOD_W-1:0] m);
    fix_sign = (neg && r != '0) ? m - r : r;
  endfunction

  assign u_mag = u_q[MOD_W+1] ? (MOD_W+2)'(0) - u_q : u_q;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod_q[OPND_W-1:0];
    div_divisor  = modulus_i;
    case (cmd_i)
      CMD_DIV_A: begin
        div_start    = 1'b1;
        div_dividend = xa_q[OPND_W-1] ? OPND_W'(0) - xa_q : xa_q;
      end
      CMD_DIV_B: begin
        div_start    = 1'b1;
        div_dividend = xb_q[OPND_W-1] ? OPND_W'(0) - xb_q : xb_q;
      end
      CMD_DIV_P: div_start = 1'b1;
      CMD_DIV_E: begin
        div_start    = 1'b1;
        div_dividend = {{(OPND_W-MOD_W-1){1'b0}}, ea_q};
        div_divisor  = eb_q[MOD_W-1:0];
      end
      CMD_DIV_U: begin
        div_start    = 1'b1;
        div_dividend = {{(OPND_W-MOD_W-2){1'b0}}, u_mag};
      end
      default: ;
    endcase
  end

  mau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Multiplier operand select; the product is registered into prod_q.
  always_comb begin
    mul_x = {2'b00, a_q};
    mul_y = {2'b00, b_q};
    case (cmd_i)
      CMD_MUL_RT: begin mul_x = {2'b00, res_q}; mul_y = {2'b00, t_q}; end
      CMD_MUL_TT: begin mul_x = {2'b00, t_q};   mul_y = {2'b00, t_q}; end
      CMD_MUL_QV: begin mul_x = {1'b0, div_quot[MOD_W:0]}; mul_y = v_q; end
      CMD_MUL_AI: begin mul_x = {2'b00, a_q};   mul_y = {2'b00, inv_q}; end
      default: ;
    endcase
  end

  assign sum_ab = {1'b0, a_q} + {1'b0, b_q};
  assign inv_src = (op_q == OP_DIV) ? b_q : a_q;

  always_comb begin
    case (op_q)
      OP_ADD:  simple_res = (sum_ab >= {1'b0, modulus_i}) ?
                            MOD_W'(sum_ab - {1'b0, modulus_i}) : sum_ab[MOD_W-1:0];
      OP_SUB:  simple_res = (a_q >= b_q) ? a_q - b_q : MOD_W'(sum_ab - {b_q, 1'b0})
                            + modulus_i;
      OP_NEG:  simple_res = (a_q == '0) ? '0 : modulus_i - a_q;
      default: simple_res = a_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q <= op_i;
        xa_q <= operand_a_i;
        xb_q <= operand_b_i;
        e_q  <= exponent_i;
      end
      CMD_SET_A:   a_q <= fix_sign(div_rem, xa_q[OPND_W-1], modulus_i);
      CMD_SET_B:   b_q <= fix_sign(div_rem, xb_q[OPND_W-1], modulus_i);
      CMD_SIMPLE:  res_q <= simple_res;
      CMD_MUL_AB, CMD_MUL_RT, CMD_MUL_TT, CMD_MUL_QV, CMD_MUL_AI:
        prod_q <= mul_x * mul_y;
      CMD_SET_RES: res_q <= div_rem;
      CMD_SET_T: begin
        t_q <= div_rem;
        n_q <= n_q >> 1;
      end
      CMD_POW_INIT: begin
        res_q <= MOD_W'(1);
        t_q   <= a_q;
        n_q   <= e_q[MOD_W-1:0];
      end
      CMD_INV_INIT: begin
        ea_q <= {1'b0, inv_src};
        eb_q <= {1'b0, modulus_i};
        u_q  <= (MOD_W+2)'(1);
        v_q  <= '0;
      end
      CMD_EUC_STEP: begin
        ea_q <= eb_q;
        eb_q <= {1'b0, div_rem};
        u_q  <= v_q;
        v_q  <= u_q - prod_q[MOD_W+1:0];
      end
      CMD_SET_INV: begin
        inv_q <= fix_sign(div_rem, u_q[MOD_W+1], modulus_i);
        res_q <= fix_sign(div_rem, u_q[MOD_W+1], modulus_i);
      end
      default: ;
    endcase
  end

  assign status_o.div_done = div_done;
  assign status_o.op       = op_q;
  assign status_o.exp_neg  = e_q[EXP_W-1];
  assign status_o.n_zero   = (n_q == '0);
  assign status_o.n_lsb    = n_q[0];
  assign status_o.eb_zero  = (eb_q == '0);

  assign result_o = res_q;
  assign equal_o  = (a_q == b_q);
  assign less_o   = (a_q < b_q);
endmodule

### rtl/mau_ctrl.sv
// Controller: sequences reduction, op dispatch, power and Euclid loops.
// Uses mau_pkg; drives commands into mau_datapath, reads its status.
module mau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_hold_i,
  input  mau_pkg::status_t  status_i,
  output logic              in_ready_o,
  output logic              out_load_o,
  output mau_pkg::cmd_e     cmd_o
);
  import mau_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RA, S_WA, S_SA, S_RB, S_WB, S_SB, S_SIMPLE,
    S_MAB, S_PD, S_PW, S_PR, S_PINIT, S_PLOOP, S_PMR, S_PSQ,
    S_IINIT, S_ILOOP, S_IDE, S_IWE, S_IQV, S_IST, S_IU, S_IWU, S_ISI, S_MAI, S_FIN
  } state_e;

  typedef enum logic [1:0] { CTX_RES, CTX_POW_R, CTX_POW_T } ctx_e;

  state_e state_q, state_d;
  ctx_e   ctx_q, ctx_d;

  always_comb begin
    state_d    = state_q;
    ctx_d      = ctx_q;
    cmd_o      = CMD_NONE;
    out_load_o = 1'b0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin cmd_o = CMD_LOAD; state_d = S_RA; end
      S_RA:   begin cmd_o = CMD_DIV_A; state_d = S_WA; end
      S_WA:   if (status_i.div_done) state_d = S_SA;
      S_SA:   begin cmd_o = CMD_SET_A; state_d = S_RB; end
      S_RB:   begin cmd_o = CMD_DIV_B; state_d = S_WB; end
      S_WB:   if (status_i.div_done) state_d = S_SB;
      S_SB: begin
        cmd_o = CMD_SET_B;
        case (status_i.op)
          OP_MUL:          state_d = S_MAB;
          OP_POW:          state_d = S_PINIT;
          OP_DIV, OP_INV:  state_d = S_IINIT;
          default:         state_d = S_SIMPLE;
        endcase
      end
      S_SIMPLE: begin cmd_o = CMD_SIMPLE; state_d = S_FIN; end
      S_MAB: begin cmd_o = CMD_MUL_AB; ctx_d = CTX_RES; state_d = S_PD; end
      S_PD:  begin cmd_o = CMD_DIV_P; state_d = S_PW; end
      S_PW:  if (status_i.div_done) state_d = S_PR;
      S_PR: begin
        cmd_o = (ctx_q == CTX_POW_T) ? CMD_SET_T : CMD_SET_RES;
        case (ctx_q)
          CTX_POW_R: state_d = S_PSQ;
          CTX_POW_T: state_d = S_PLOOP;
          default:   state_d = S_FIN;
        endcase
      end
      S_PINIT: begin cmd_o = CMD_POW_INIT; state_d = S_PLOOP; end
      S_PLOOP: begin
        if (status_i.exp_neg || status_i.n_zero) state_d = S_FIN;
        else if (status_i.n_lsb)                 state_d = S_PMR;
        else                                     state_d = S_PSQ;
      end
      S_PMR: begin cmd_o = CMD_MUL_RT; ctx_d = CTX_POW_R; state_d = S_PD; end
      S_PSQ: begin cmd_o = CMD_MUL_TT; ctx_d = CTX_POW_T; state_d = S_PD; end
      S_IINIT: begin cmd_o = CMD_INV_INIT; state_d = S_ILOOP; end
      S_ILOOP: state_d = status_i.eb_zero ? S_IU : S_IDE;
      S_IDE: begin cmd_o = CMD_DIV_E; state_d = S_IWE; end
      S_IWE: if (status_i.div_done) state_d = S_IQV;
      S_IQV: begin cmd_o = CMD_MUL_QV; state_d = S_IST; end
      S_IST: begin cmd_o = CMD_EUC_STEP; state_d = S_ILOOP; end
      S_IU:  begin cmd_o = CMD_DIV_U; state_d = S_IWU; end
      S_IWU: if (status_i.div_done) state_d = S_ISI;
      S_ISI: begin
        cmd_o   = CMD_SET_INV;
        state_d = (status_i.op == OP_INV) ? S_FIN : S_MAI;
      end
      S_MAI: begin cmd_o = CMD_MUL_AI; ctx_d = CTX_RES; state_d = S_PD; end
      S_FIN: if (!out_hold_i) begin out_load_o = 1'b1; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ctx_q   <= CTX_RES;
    end else begin
      state_q <= state_d;
      ctx_q   <= ctx_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
endmodule

### rtl/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit: modulus register, output word.
// Uses mau_pkg, mau_ctrl and mau_datapath.
//
// Usage: an input word carries the opcode in s_axis_tuser and the two signed
// 64-bit operands plus the signed exponent in s_axis_tdata. One result word
// leaves on the master side with the residue and the equal/less flags.
// The modulus must be written through cfg_we_i/cfg_wdata_i only while the unit
// is idle; the block does not enforce this. A value below 2 acts as 2.
// Each operand reduction runs through the bit-serial divider. A simple op
// first reduces both operands; mul adds one more reduction for the product,
// pow adds per exponent bit a squaring and, for a set bit, a multiply, each
// with its own reduction (up to 31 exponent bits), and inverse/div run a
// division and a product per Euclid step (at most about 45 steps) plus a
// final reduction of the coefficient; div adds the last product and its reduction.
// The divider is the single shared unit; one word is in work at a time, and a
// new word is taken while a finished result waits.
// Reset restores the modulus to 1000000007 and empties the output register.
// When the receiver stalls, the result holds in m_axis_tdata; a following
// result waits in the controller until that word is taken.
module modular_arithmetic_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mau_pkg::MOD_W-1:0]   cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [63:0] operand_a, [127:64] operand_b, [159:128] exponent
  input  logic [159:0]                s_axis_tdata,
  // [2:0] op
  input  logic [mau_pkg::OP_W-1:0]    s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [30:0] result, [31] equal_flag, [32] less_flag, [39:33] zero
  output logic [39:0]                 m_axis_tdata
);
  import mau_pkg::*;

  logic [MOD_W-1:0] cfg_q, mod_eff;
  logic             out_valid_q;
  logic [MOD_W+1:0] out_data_q;
  logic             out_hold, out_load;
  cmd_e             cmd;
  status_t          status;
  logic [MOD_W-1:0] dp_result;
  logic             dp_equal, dp_less;

  // Hold the modulus; clamp tiny values to 2.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_q <= RESET_MODULUS;
    else if (cfg_we_i) cfg_q <= cfg_wdata_i;
  end
  assign mod_eff = (cfg_q < MOD_W'(2)) ? MOD_W'(2) : cfg_q;

  assign out_hold = out_valid_q && !m_axis_tready;

  mau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_hold_i (out_hold),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .out_load_o (out_load),
    .cmd_o      (cmd)
  );

  mau_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .modulus_i   (mod_eff),
    .op_i        (s_axis_tuser),
    .operand_a_i (s_axis_tdata[63:0]),
    .operand_b_i (s_axis_tdata[127:64]),
    .exponent_i  (s_axis_tdata[159:128]),
    .status_o    (status),
    .result_o    (dp_result),
    .equal_o     (dp_equal),
    .less_o      (dp_less)
  );

  // Output word register: load on finish, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= {dp_less, dp_equal, dp_result};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_data_q};
endmodule
